// ----- rtl/assert_macros.svh -----
// Assertion helper macros used by the verification checker.
// No dependencies; included by files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define PDT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pdt checker: same-cycle implication failed");

// Next-cycle implication, disabled while reset is high.
`define PDT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pdt checker: next-cycle implication failed");

// Next-cycle implication that is checked during reset as well.
`define PDT_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("pdt checker: next-cycle check failed");

`endif

// ----- rtl/pdt_pkg.sv -----
// Shared types, codes and constants of the press dwell timer controller.
// No dependencies; used by every other file of the block except assert_macros.svh.
package pdt_pkg;

   // Field widths
   localparam int MODE_W     = 2;
   localparam int PRESS_W    = 21;
   localparam int ACTION_W   = 2;
   localparam int KIND_W     = 2;
   localparam int STATE_W    = 2;
   localparam int SECS_W     = 12;
   localparam int THR_W      = 20;
   localparam int STEP_W     = 10;
   localparam int PSTEP_W    = 17;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;
   localparam int MAX_MSGS   = 3;
   localparam int CNT_W      = 2;

   // Parameter defaults
   localparam int DEFAULT_SECONDS_DEF  = 60;
   localparam int TICKS_PER_SECOND_DEF = 1000;

   // Largest elapsed second count
   localparam logic [SECS_W-1:0] SECS_MAX = '1;

   // Reciprocal of ten scaled by 2**24, exact for magnitudes below 2**22
   localparam int                  DIV10_SHIFT = 24;
   localparam logic [PRESS_W-1:0]  DIV10_MULT  = PRESS_W'(1677722);

   // Input item kinds
   localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ACTION = 2'd1;
   localparam logic [MODE_W-1:0] MODE_TICK   = 2'd2;

   // User actions
   localparam logic [ACTION_W-1:0] ACT_INC  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_DEC  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_ACK  = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_TARE = 2'd3;

   // Message kinds
   localparam logic [KIND_W-1:0] KIND_PRESSURE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_STATE    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DISPLAY  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_SETTING  = 2'd3;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_STEP      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MIN       = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MAX       = 2'd3;

   // Configuration reset values
   localparam logic [THR_W-1:0]  THRESHOLD_RST = THR_W'(1000);
   localparam logic [STEP_W-1:0] STEP_RST      = STEP_W'(5);
   localparam logic [SECS_W-1:0] MIN_RST       = SECS_W'(5);
   localparam logic [SECS_W-1:0] MAX_RST       = SECS_W'(600);

   typedef struct packed {
      logic [THR_W-1:0]  threshold;
      logic [STEP_W-1:0] step_secs;
      logic [SECS_W-1:0] min_secs;
      logic [SECS_W-1:0] max_secs;
   } cfg_type;

   typedef struct packed {
      logic [MODE_W-1:0]          mode;
      logic signed [PRESS_W-1:0]  pressure;
      logic [ACTION_W-1:0]        action;
   } item_type;

   typedef struct packed {
      logic [KIND_W-1:0]         kind;
      logic signed [PRESS_W-1:0] pressure;
      logic [STATE_W-1:0]        state;
      logic [SECS_W-1:0]         secs;
   } msg_type;

endpackage

// ----- rtl/pdt_if.sv -----
// Valid/ready channel interfaces for the request and response sides.
// Depends on pdt_pkg for field widths.
interface pdt_req_if;
   import pdt_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [MODE_W-1:0]          mode;
   logic signed [PRESS_W-1:0]  pressure_grams;
   logic [ACTION_W-1:0]        action_code;

   modport source (output valid, mode, pressure_grams, action_code, input ready);
   modport sink   (input valid, mode, pressure_grams, action_code, output ready);
endinterface

interface pdt_rsp_if;
   import pdt_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [KIND_W-1:0]          message_kind;
   logic signed [PRESS_W-1:0]  shown_pressure;
   logic [STATE_W-1:0]         machine_state;
   logic [SECS_W-1:0]          timer_seconds;
   logic                       last;

   modport source (output valid, message_kind, shown_pressure, machine_state,
                   timer_seconds, last, input ready);
   modport sink   (input valid, message_kind, shown_pressure, machine_state,
                   timer_seconds, last, output ready);
endinterface

// ----- rtl/press_dwell_timer_controller_unit.sv -----
// Top level of the press dwell timer controller: input register, CSRs and submodules.
// Depends on pdt_pkg, pdt_if, pdt_engine and pdt_msg_queue.
//
// Usage: req_bus carries one transaction per item: a pressure sample, a user
// action or a one-millisecond tick. rsp_bus returns zero to three messages per
// item in order; last marks the final message of each item. Items that cause no
// message (a tick outside timing, an acknowledge outside alert, mode 3) are
// consumed silently. The csr_ port writes the four configuration registers and
// must be used only while the block is idle; the block itself does not enforce this.
// Flow: an accepted request waits in the input register until the message buffer
// can load, is processed as it loads, and its first message is then offered on rsp_bus.
// Throughput: one item per cycle for silent items while the message buffer is empty;
// otherwise the next item waits until the final message of the last one is taken, so
// the single response port draining the three-entry message buffer sets the pace.
// Reset: synchronous, active high; the machine starts in calibrating with the
// default duration, the buffer empty and configuration at its reset values.
// Stall: while rsp_bus.ready is low the offered message holds, one further item
// waits in the input register and then req_bus.ready drops.
module press_dwell_timer_controller_unit #(
   parameter int DEFAULT_SECONDS  = pdt_pkg::DEFAULT_SECONDS_DEF,
   parameter int TICKS_PER_SECOND = pdt_pkg::TICKS_PER_SECOND_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   pdt_req_if.sink                         req_bus,
   pdt_rsp_if.source                       rsp_bus,
   input  logic                            csr_we,
   input  logic [pdt_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pdt_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import pdt_pkg::*;

   cfg_type           cfg_ff;
   logic              in_valid_ff;
   item_type          in_item_ff;
   logic              take;
   logic              can_load;
   msg_type           msgs [MAX_MSGS];
   logic [CNT_W-1:0]  msg_count;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold <= THRESHOLD_RST;
         cfg_ff.step_secs <= STEP_RST;
         cfg_ff.min_secs  <= MIN_RST;
         cfg_ff.max_secs  <= MAX_RST;
      end else if (csr_we) begin
         case (csr_index)
            REG_THRESHOLD: cfg_ff.threshold <= csr_wdata[THR_W-1:0];
            REG_STEP:      cfg_ff.step_secs <= csr_wdata[STEP_W-1:0];
            REG_MIN:       cfg_ff.min_secs  <= csr_wdata[SECS_W-1:0];
            REG_MAX:       cfg_ff.max_secs  <= csr_wdata[SECS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Input register: refilled whenever it is empty or being processed.
   assign take          = in_valid_ff && can_load;
   assign req_bus.ready = !in_valid_ff || take;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         in_item_ff.mode     <= req_bus.mode;
         in_item_ff.pressure <= req_bus.pressure_grams;
         in_item_ff.action   <= req_bus.action_code;
      end
   end

   pdt_engine #(
      .DEFAULT_SECONDS  (DEFAULT_SECONDS),
      .TICKS_PER_SECOND (TICKS_PER_SECOND)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .item      (in_item_ff),
      .take      (take),
      .msgs      (msgs),
      .msg_count (msg_count)
   );

   pdt_msg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .load      (take),
      .msgs      (msgs),
      .msg_count (msg_count),
      .can_load  (can_load),
      .rsp       (rsp_bus)
   );

endmodule

// ----- rtl/pdt_engine.sv -----
// Controller state and per-transaction message generation of the dwell timer.
// Depends on pdt_pkg for types and codes.
module pdt_engine #(
   parameter int DEFAULT_SECONDS  = pdt_pkg::DEFAULT_SECONDS_DEF,
   parameter int TICKS_PER_SECOND = pdt_pkg::TICKS_PER_SECOND_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pdt_pkg::cfg_type              cfg,
   input  pdt_pkg::item_type             item,
   input  logic                          take,
   output pdt_pkg::msg_type              msgs [pdt_pkg::MAX_MSGS],
   output logic [pdt_pkg::CNT_W-1:0]     msg_count
);
   import pdt_pkg::*;

   localparam int MS_W = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;
   localparam logic [MS_W:0] TICKS = (MS_W + 1)'(TICKS_PER_SECOND);

   typedef enum logic [STATE_W-1:0] {
      ST_CAL    = 2'd0,
      ST_IDLE   = 2'd1,
      ST_TIMING = 2'd2,
      ST_ALERT  = 2'd3
   } state_type;

   state_type                  state_ff, state_in;
   logic [SECS_W-1:0]          dur_ff, dur_in;
   logic [MS_W-1:0]            ms_ff, ms_in;
   logic [SECS_W-1:0]          el_ff, el_in;
   logic signed [PSTEP_W-1:0]  shown_step_ff, shown_step_in;
   logic                       shown_valid_ff, shown_valid_in;

   // Divide the sample by ten toward zero through a scaled reciprocal.
   logic                       press_neg;
   logic [PRESS_W-1:0]         press_mag;
   logic [2*PRESS_W-1:0]       press_prod;
   logic [PSTEP_W-1:0]         quot_mag;
   logic signed [PSTEP_W-1:0]  press_step;
   logic                       above;

   assign press_neg  = item.pressure[PRESS_W-1];
   assign press_mag  = press_neg ? PRESS_W'(-item.pressure) : PRESS_W'(item.pressure);
   assign press_prod = {{PRESS_W{1'b0}}, press_mag} * {{PRESS_W{1'b0}}, DIV10_MULT};
   assign quot_mag   = press_prod[DIV10_SHIFT +: PSTEP_W];
   assign press_step = press_neg ? -signed'(quot_mag) : signed'(quot_mag);
   assign above      = $signed({item.pressure[PRESS_W-1], item.pressure})
                       > $signed({2'b00, cfg.threshold});

   // Duration arithmetic for the increment and decrement actions.
   logic [SECS_W:0]            inc_sum;
   logic signed [SECS_W+1:0]   dec_diff;
   logic [SECS_W-1:0]          inc_secs, dec_secs;

   assign inc_sum  = {1'b0, dur_ff} + {3'b000, cfg.step_secs};
   assign dec_diff = $signed({2'b00, dur_ff}) - $signed({4'b0000, cfg.step_secs});
   assign inc_secs = (inc_sum > {1'b0, cfg.max_secs}) ? cfg.max_secs : inc_sum[SECS_W-1:0];
   assign dec_secs = (dec_diff < $signed({2'b00, cfg.min_secs})) ? cfg.min_secs
                                                                : dec_diff[SECS_W-1:0];

   // Millisecond counter step while timing.
   logic [MS_W:0]              ms_next;
   logic                       ms_wrap;
   logic [SECS_W-1:0]          el_tick;

   assign ms_next = {1'b0, ms_ff} + {{MS_W{1'b0}}, 1'b1};
   assign ms_wrap = ms_next >= TICKS;
   assign el_tick = (ms_wrap && el_ff != SECS_MAX) ? el_ff + SECS_W'(1) : el_ff;

   // Next state and the ordered list of messages for this transaction.
   logic       enter;
   logic       dur_msg;
   state_type  enter_st;
   logic [CNT_W-1:0] n;

   always_comb begin
      state_in       = state_ff;
      dur_in         = dur_ff;
      ms_in          = ms_ff;
      el_in          = el_ff;
      shown_step_in  = shown_step_ff;
      shown_valid_in = shown_valid_ff;
      enter          = 1'b0;
      enter_st       = state_ff;
      dur_msg        = 1'b0;
      n              = '0;
      for (int i = 0; i < MAX_MSGS; i++) begin
         msgs[i] = '0;
      end

      case (item.mode)
         MODE_SAMPLE: begin
            if (!shown_valid_ff || press_step != shown_step_ff) begin
               shown_valid_in = 1'b1;
               shown_step_in  = press_step;
               msgs[n].kind     = KIND_PRESSURE;
               msgs[n].pressure = item.pressure;
               n = n + CNT_W'(1);
            end
            case (state_ff)
               ST_CAL: begin
                  enter    = 1'b1;
                  enter_st = ST_IDLE;
               end
               ST_IDLE: begin
                  if (above) begin
                     ms_in    = '0;
                     el_in    = '0;
                     enter    = 1'b1;
                     enter_st = ST_TIMING;
                  end
               end
               default: begin
                  if (!above) begin
                     enter    = 1'b1;
                     enter_st = ST_IDLE;
                  end
               end
            endcase
         end
         MODE_ACTION: begin
            case (item.action)
               ACT_INC: begin
                  dur_in  = inc_secs;
                  dur_msg = 1'b1;
               end
               ACT_DEC: begin
                  dur_in  = dec_secs;
                  dur_msg = 1'b1;
               end
               ACT_ACK: begin
                  if (state_ff == ST_ALERT) begin
                     enter    = 1'b1;
                     enter_st = ST_IDLE;
                  end
               end
               default: begin
                  enter    = 1'b1;
                  enter_st = ST_CAL;
               end
            endcase
         end
         MODE_TICK: begin
            if (state_ff == ST_TIMING) begin
               ms_in = ms_wrap ? '0 : ms_next[MS_W-1:0];
               el_in = el_tick;
               if (el_tick >= dur_ff) begin
                  enter    = 1'b1;
                  enter_st = ST_ALERT;
               end
            end
         end
         default: begin
         end
      endcase

      // State entry reports the new state, and idle also shows the duration.
      if (enter) begin
         state_in      = enter_st;
         msgs[n].kind  = KIND_STATE;
         msgs[n].state = enter_st;
         n = n + CNT_W'(1);
         if (enter_st == ST_IDLE) begin
            msgs[n].kind = KIND_DISPLAY;
            msgs[n].secs = dur_ff;
            n = n + CNT_W'(1);
         end
      end

      // A duration change is shown and then reported as the new setting.
      if (dur_msg) begin
         msgs[0].kind = KIND_DISPLAY;
         msgs[0].secs = dur_in;
         msgs[1].kind = KIND_SETTING;
         msgs[1].secs = dur_in;
         n = CNT_W'(2);
      end
      msg_count = n;
   end

   // Controller state registers, updated once per processed transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CAL;
         dur_ff         <= SECS_W'(DEFAULT_SECONDS);
         ms_ff          <= '0;
         el_ff          <= '0;
         shown_step_ff  <= '0;
         shown_valid_ff <= 1'b0;
      end else if (take) begin
         state_ff       <= state_in;
         dur_ff         <= dur_in;
         ms_ff          <= ms_in;
         el_ff          <= el_in;
         shown_step_ff  <= shown_step_in;
         shown_valid_ff <= shown_valid_in;
      end
   end

endmodule

// ----- rtl/pdt_msg_queue.sv -----
// Result buffer that holds up to three messages of one transaction and drains them.
// Depends on pdt_pkg and the response channel interface.
module pdt_msg_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       load,
   input  pdt_pkg::msg_type           msgs [pdt_pkg::MAX_MSGS],
   input  logic [pdt_pkg::CNT_W-1:0]  msg_count,
   output logic                       can_load,
   pdt_rsp_if.source                  rsp
);
   import pdt_pkg::*;

   msg_type           buf_ff [MAX_MSGS];
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  hd_ff, hd_in;
   logic              pop;

   assign pop      = rsp.valid && rsp.ready;
   assign can_load = (rem_ff == '0) || (rem_ff == CNT_W'(1) && rsp.ready);

   // Present the head message; the last one of a transaction is flagged.
   assign rsp.valid          = rem_ff != '0;
   assign rsp.message_kind   = buf_ff[hd_ff].kind;
   assign rsp.shown_pressure = buf_ff[hd_ff].pressure;
   assign rsp.machine_state  = buf_ff[hd_ff].state;
   assign rsp.timer_seconds  = buf_ff[hd_ff].secs;
   assign rsp.last           = rem_ff == CNT_W'(1);

   // Load a fresh list or step the head; the head returns to zero when empty.
   always_comb begin
      rem_in = rem_ff;
      hd_in  = hd_ff;
      if (load) begin
         rem_in = msg_count;
         hd_in  = '0;
      end else if (pop) begin
         rem_in = rem_ff - CNT_W'(1);
         hd_in  = (rem_ff == CNT_W'(1)) ? '0 : hd_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
         hd_ff  <= '0;
      end else begin
         rem_ff <= rem_in;
         hd_ff  <= hd_in;
      end
   end

   // Message storage carries no reset.
   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < MAX_MSGS; i++) begin
            buf_ff[i] <= msgs[i];
         end
      end
   end

endmodule

// ----- rtl/pdt_checker.sv -----
// Port-level checks of the dwell timer's response channel, bound to the top level.
// Depends on pdt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pdt_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [pdt_pkg::KIND_W-1:0]      rsp_kind,
   input logic [pdt_pkg::PRESS_W-1:0]     rsp_pressure,
   input logic [pdt_pkg::STATE_W-1:0]     rsp_state,
   input logic [pdt_pkg::SECS_W-1:0]      rsp_secs,
   input logic                            rsp_last
);
   import pdt_pkg::*;

   // No message is offered right after reset.
   `PDT_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)

   // A stalled message holds its contents.
   `PDT_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_kind) && $stable(rsp_pressure) && $stable(rsp_state) &&
      $stable(rsp_secs) && $stable(rsp_last))

   // Messages of one transaction follow each other without a gap.
   `PDT_ASSERT_NEXT(a_burst_contiguous, clock, reset, rsp_valid && rsp_ready && !rsp_last,
      rsp_valid)

   // Only pressure messages carry a pressure value.
   `PDT_ASSERT_IMPLY(a_pressure_only_kind0, clock, reset,
      rsp_valid && rsp_kind != KIND_PRESSURE, rsp_pressure == '0)

   // Pressure messages carry neither a state nor a time.
   `PDT_ASSERT_IMPLY(a_kind0_fields, clock, reset, rsp_valid && rsp_kind == KIND_PRESSURE,
      rsp_state == '0 && rsp_secs == '0)

endmodule

bind press_dwell_timer_controller_unit pdt_checker u_pdt_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .rsp_kind     (rsp_bus.message_kind),
   .rsp_pressure (rsp_bus.shown_pressure),
   .rsp_state    (rsp_bus.machine_state),
   .rsp_secs     (rsp_bus.timer_seconds),
   .rsp_last     (rsp_bus.last)
);
